### src/postfix_boolean_evaluator_defines.svh
// Assertion macros for the postfix boolean evaluator.
// Both macros expect signals named clk and rst in the scope where they are used.
`ifndef POSTFIX_BOOLEAN_EVALUATOR_DEFINES_SVH
`define POSTFIX_BOOLEAN_EVALUATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside of reset.
`define PBE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("postfix evaluator: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define PBE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("postfix evaluator: next-cycle check failed");

`else

`define PBE_ASSERT_IMP(label, ante, cons)
`define PBE_ASSERT_NXT(label, ante, cons)

`endif

`endif

### src/pbe_pkg.sv
`default_nettype none

package pbe_pkg;

  // Field widths.
  localparam int unsigned TOKEN_W = 8;
  localparam int unsigned ROW_W   = 26;
  localparam int unsigned VAR_W   = 5;

  // Defaults.
  localparam int unsigned        STACK_DEPTH_DEF = 64;
  localparam logic [VAR_W-1:0]   NUM_VARS_RESET  = 5'd1;

  // Token codes (ASCII).
  localparam logic [TOKEN_W-1:0] TOK_OR   = 8'h7C;  // '|'
  localparam logic [TOKEN_W-1:0] TOK_AND  = 8'h26;  // '&'
  localparam logic [TOKEN_W-1:0] TOK_XOR  = 8'h23;  // '#'
  localparam logic [TOKEN_W-1:0] TOK_IMP  = 8'h3E;  // '>'
  localparam logic [TOKEN_W-1:0] TOK_EQV  = 8'h3D;  // '='
  localparam logic [TOKEN_W-1:0] TOK_NOT  = 8'h2D;  // '-'
  localparam logic [TOKEN_W-1:0] TOK_ONE  = 8'h31;  // '1'
  localparam logic [TOKEN_W-1:0] TOK_ZERO = 8'h30;  // '0'
  localparam logic [TOKEN_W-1:0] TOK_A    = 8'h61;  // 'a'
  localparam logic [TOKEN_W-1:0] TOK_Z    = TOK_A + 8'd25;

  // What a token did.
  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_OP     = 2'd1,
    KIND_IGNORE = 2'd2
  } step_kind_t;

  // One result item.
  typedef struct packed {
    step_kind_t kind;
    logic       value;
    logic       done;
    logic       fin;
    logic       err;
  } res_t;

endpackage

`default_nettype wire

### src/pbe_stack.sv
`default_nettype none

module pbe_stack #(
  parameter int unsigned DEPTH = pbe_pkg::STACK_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [pbe_pkg::VAR_W-1:0]  cfg_wr_data,
  input  logic                       fire,
  input  logic [pbe_pkg::TOKEN_W-1:0] token,
  input  logic [pbe_pkg::ROW_W-1:0]  row,
  input  logic                       last_token,
  output pbe_pkg::res_t              res
);
  import pbe_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned DW = $clog2(DEPTH + 1);

  // Entries below the top of stack; the top itself lives in a register.
  logic mem [DEPTH];

  logic [DW-1:0]    depth, depth_next;
  logic             err_seen, err_seen_next;
  logic             tos, tos_next;
  logic             rd_data;
  logic             fwd, fwd_data;
  logic             nos;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [VAR_W-1:0] num_vars;

  logic             is_bin, is_neg, is_push;
  logic             push_val, op_val;
  logic [VAR_W-1:0] lidx, shamt;
  logic [TOKEN_W-1:0] loff;
  logic             letter_bit;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_vars <= NUM_VARS_RESET;
    end else if (cfg_wr_en) begin
      num_vars <= cfg_wr_data;
    end
  end

  // Second entry comes from the memory, or from last cycle's write to it.
  assign nos = fwd ? fwd_data : rd_data;

  // Variable lookup: letter i takes row bit num_vars-1-i.
  always_comb begin
    loff  = token - TOK_A;
    lidx  = loff[VAR_W-1:0];
    shamt = num_vars - VAR_W'(1) - lidx;
    letter_bit = 1'b0;
    if (lidx < num_vars && shamt < VAR_W'(ROW_W)) begin
      letter_bit = row[shamt];
    end
  end

  // Token decode and operator value.
  always_comb begin
    is_bin   = 1'b0;
    is_neg   = 1'b0;
    is_push  = 1'b0;
    push_val = 1'b0;
    op_val   = 1'b0;
    unique case (token)
      TOK_OR: begin
        is_bin = 1'b1;
        op_val = nos | tos;
      end
      TOK_AND: begin
        is_bin = 1'b1;
        op_val = nos & tos;
      end
      TOK_XOR: begin
        is_bin = 1'b1;
        op_val = nos ^ tos;
      end
      TOK_IMP: begin
        is_bin = 1'b1;
        op_val = ~nos | tos;
      end
      TOK_EQV: begin
        is_bin = 1'b1;
        op_val = ~(nos ^ tos);
      end
      TOK_NOT: begin
        is_neg = 1'b1;
        op_val = ~tos;
      end
      TOK_ZERO: begin
        is_push = 1'b1;
      end
      TOK_ONE: begin
        is_push  = 1'b1;
        push_val = 1'b1;
      end
      default: begin
        if (token >= TOK_A && token <= TOK_Z) begin
          is_push  = 1'b1;
          push_val = letter_bit;
        end
      end
    endcase
  end

  // Stack update and result for the accepted item.
  always_comb begin
    depth_next    = depth;
    tos_next      = tos;
    err_seen_next = err_seen;
    we            = 1'b0;
    waddr         = AW'(depth - DW'(1));
    res.kind      = KIND_IGNORE;
    res.value     = 1'b0;
    res.done      = last_token;
    res.fin       = 1'b0;
    res.err       = 1'b0;

    if (is_push) begin
      res.kind = KIND_PUSH;
      if (depth == DW'(DEPTH)) begin
        err_seen_next = 1'b1;
      end else begin
        we          = fire && (depth != DW'(0));
        tos_next    = push_val;
        depth_next  = depth + DW'(1);
      end
    end else if (is_bin) begin
      res.kind = KIND_OP;
      if (depth < DW'(2)) begin
        err_seen_next = 1'b1;
      end else begin
        res.value  = op_val;
        tos_next   = op_val;
        depth_next = depth - DW'(1);
      end
    end else if (is_neg) begin
      res.kind = KIND_OP;
      if (depth == DW'(0)) begin
        err_seen_next = 1'b1;
      end else begin
        res.value = op_val;
        tos_next  = op_val;
      end
    end

    // The last token reports the top and starts a fresh formula.
    if (last_token) begin
      if (depth_next == DW'(0)) begin
        err_seen_next = 1'b1;
      end else begin
        res.fin = tos_next;
      end
    end
    res.err = err_seen_next;
    if (last_token) begin
      depth_next    = '0;
      err_seen_next = 1'b0;
    end

    // Fetch the second entry for the depth that holds in the next cycle.
    raddr = AW'((fire ? depth_next : depth) - DW'(2));
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth    <= '0;
      err_seen <= 1'b0;
      fwd      <= 1'b0;
    end else begin
      fwd <= we;
      if (fire) begin
        depth    <= depth_next;
        err_seen <= err_seen_next;
      end
    end
  end

  // Top of stack and forwarded write data.
  always_ff @(posedge clk) begin
    fwd_data <= tos;
    if (fire) begin
      tos <= tos_next;
    end
  end

  // Stack memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= tos;
    end
    rd_data <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/pbe_out_buf.sv
`default_nettype none

module pbe_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pbe_pkg::res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output pbe_pkg::res_t out_data
);
  import pbe_pkg::*;

  // Two-entry queue so the input side never waits on the output stall directly.
  res_t       slots [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign out_data  = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### src/postfix_boolean_evaluator.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid, in_stall   token, row, last_token
// output    out        out_valid, out_stall step_kind, step_value, done_res,
//                                           final_value, error
// config    in         cfg_wr_en            cfg_wr_data (num_vars)
//
// One item per cycle while in_stall is low; results are registered in a queue.
// The operand stack sits in a one-read, one-write memory with the top held in
// a register; a push forwards its write to the next cycle's second-entry read.
// Reset is synchronous: empty stack, error clear, num_vars back to 1.
// A two-entry output queue lets items keep flowing while a result is stalled;
// in_stall rises only when both entries are occupied.
`default_nettype none

`include "postfix_boolean_evaluator_defines.svh"

module postfix_boolean_evaluator #(
  parameter int unsigned STACK_DEPTH = pbe_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [pbe_pkg::VAR_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pbe_pkg::TOKEN_W-1:0] token,
  input  logic [pbe_pkg::ROW_W-1:0]   row,
  input  logic                        last_token,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  step_kind,
  output logic                        step_value,
  output logic                        done_res,
  output logic                        final_value,
  output logic                        error
);
  import pbe_pkg::*;

  logic fire;
  res_t step_res;
  res_t head;

  assign fire = in_valid && !in_stall;

  // Stack engine.
  pbe_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .token       (token),
    .row         (row),
    .last_token  (last_token),
    .res         (step_res)
  );

  // Result queue.
  pbe_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (step_res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head)
  );

  assign step_kind   = head.kind;
  assign step_value  = head.value;
  assign done_res    = head.done;
  assign final_value = head.fin;
  assign error       = head.err;

  // A full queue always has a result to show.
  `PBE_ASSERT_IMP(a_stall_has_result, in_stall, out_valid)
  // Every accepted item leaves a result behind.
  `PBE_ASSERT_NXT(a_accept_gives_result, fire, out_valid)
  // Only operators carry a step value, and only the last token a final value.
  `PBE_ASSERT_IMP(a_value_only_for_ops, out_valid && step_kind != KIND_OP, !step_value)
  `PBE_ASSERT_IMP(a_final_only_when_done, out_valid && !done_res, !final_value)

endmodule

`default_nettype wire
